// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed by a property from the next edge on.
`define ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hdl/nida_pkg.sv =====
// Shared constants, codes and types of the node offset allocator.
`timescale 1ns / 1ps

package nida_pkg;

   // Field widths
   localparam int OFF_W     = 16;
   localparam int CMD_W     = 2;
   localparam int ST_W      = 2;
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;

   // Default sizing
   localparam int DEF_MAX_NODES   = 65536;
   localparam int DEF_VECTOR_SIZE = 2048;

   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [ST_W-1:0]  status_type;

   // Command codes
   localparam cmd_type CMD_ALLOC  = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_TEST   = 2'd2;
   localparam cmd_type CMD_UNUSED = 2'd3;

   // Status codes
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_ALREADY = 2'd1;
   localparam status_type ST_RANGE   = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

   // Result of the highest-set-bit unit
   typedef struct packed {
      logic             done;
      logic [BIT_W-1:0] bit_idx;
   } msb_res_type;

endpackage

// ===== hdl/node_id_allocator_with_reuse_core.sv =====
// Top level of the node offset allocator with reuse of deleted offsets.
//
// Usage: commands enter on the req_ stream (tuser = command, tdata = node
// offset) and each produces exactly one transaction on the rsp_ stream
// (tdata = offset, tuser = appended, is_deleted, status). The block works on
// one command at a time; req_tready is high only while the sequencer idles.
// Steps per command, from request to result register:
//   allocate that appends, table full, unused command, out-of-range delete:
//   straight to the result state
//   delete, test: one bitmap read through the registered memory port
//   allocate that reuses: step over vector flags (one per cycle, fewer than
//   MAX_NODES/VECTOR_SIZE), walk down the flagged vector's words from the top
//   past the empty ones, find the highest set bit of the first nonzero word,
//   then read the words below the taken one to decide whether the vector
//   emptied (each walk under VECTOR_SIZE/64 words); all reads use the single port.
// The result sits in an output register; a new command is taken while it
// waits, and a stalled rsp_tready holds the sequencer in its result state.
// Reset clears the count, the flags and the deleted total at once; bitmap
// words are zeroed as the count first reaches them, so no clearing pass runs.
// VECTOR_SIZE must be a power of two from 64 up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module node_id_allocator_with_reuse_core
   import nida_pkg::*;
#(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int VECTOR_SIZE = DEF_VECTOR_SIZE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [OFF_W-1:0] req_tdata,   // [15:0] node_offset
   input  logic [CMD_W-1:0] req_tuser,   // [1:0] command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OFF_W-1:0] rsp_tdata,   // [15:0] offset_out
   output logic [3:0]       rsp_tuser    // [0] appended, [1] is_deleted, [3:2] status
);

   localparam int CW        = $clog2(MAX_NODES + 1);
   localparam int EW        = (CW > OFF_W) ? CW : OFF_W;
   localparam int NUM_WORDS = (MAX_NODES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WPV       = VECTOR_SIZE / WORD_BITS;
   localparam int WSH       = $clog2(WPV);
   localparam int WIW       = (WSH > 0) ? WSH : 1;
   localparam int NUM_VEC   = (MAX_NODES + VECTOR_SIZE - 1) / VECTOR_SIZE;
   localparam int VW        = (NUM_VEC > 1) ? $clog2(NUM_VEC) : 1;
   localparam int VSH       = $clog2(VECTOR_SIZE);
   localparam int XW        = ((EW - BIT_W) > (VW + WSH)) ? (EW - BIT_W) : (VW + WSH);
   localparam int LW        = XW + BIT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_WAIT, S_CHK, S_FLAG_SCAN, S_SCAN_WAIT, S_SCAN_CHK,
      S_MSB_WAIT, S_EMPTY_WAIT, S_EMPTY_CHK, S_RESULT
   } state_type;

   // Control state
   state_type          state_ff, state_in;
   logic [CW-1:0]      node_count_ff, node_count_in;
   logic [CW-1:0]      del_total_ff, del_total_in;
   logic [NUM_VEC-1:0] flags_ff, flags_in;
   logic [VW-1:0]      vidx_ff, vidx_in;
   logic [WIW-1:0]     widx_ff, widx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload
   cmd_type            cmd_ff, cmd_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [XW-1:0]      word_ix_ff, word_ix_in;
   logic [WORD_BITS-1:0] hold_word_ff, hold_word_in;
   logic [OFF_W-1:0]   res_off_ff, res_off_in;
   logic               res_app_ff, res_app_in;
   logic               res_isdel_ff, res_isdel_in;
   status_type         res_status_ff, res_status_in;
   logic [OFF_W-1:0]   rsp_off_ff, rsp_off_in;
   logic               rsp_app_ff, rsp_app_in;
   logic               rsp_isdel_ff, rsp_isdel_in;
   status_type         rsp_status_ff, rsp_status_in;

   // Bitmap memory
   logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   // Datapath helpers
   logic [XW-1:0]        scan_ix;
   logic [XW-1:0]        cur_ix;
   logic                 cur_live;
   logic [WORD_BITS-1:0] cur_word;
   logic [WORD_BITS-1:0] new_word;
   logic [VW-1:0]        del_vec;
   logic                 msb_start;
   msb_res_type          msb_res;

   // Word index during reuse comes from vector and word counters
   assign scan_ix  = (XW'(vidx_ff) << WSH) | XW'(widx_ff);
   assign cur_ix   = (cmd_ff == CMD_ALLOC) ? scan_ix : word_ix_ff;
   assign cur_live = ({cur_ix, {BIT_W{1'b0}}} < LW'(node_count_ff));
   assign cur_word = cur_live ? rdata_ff : '0;
   assign new_word = hold_word_ff & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << msb_res.bit_idx);
   assign del_vec  = VW'(EW'(off_ff) >> VSH);

   // Hold the bitmap; read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= bitmap_mem[cur_ix[AW-1:0]];
   end

   nida_msb u_msb (
      .clock (clock),
      .reset (reset),
      .start (msb_start),
      .word  (cur_word),
      .res   (msb_res)
   );

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      del_total_in  = del_total_ff;
      flags_in      = flags_ff;
      vidx_in       = vidx_ff;
      widx_in       = widx_ff;
      cmd_in        = cmd_ff;
      off_in        = off_ff;
      word_ix_in    = word_ix_ff;
      hold_word_in  = hold_word_ff;
      res_off_in    = res_off_ff;
      res_app_in    = res_app_ff;
      res_isdel_in  = res_isdel_ff;
      res_status_in = res_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_app_in    = rsp_app_ff;
      rsp_isdel_in  = rsp_isdel_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_we        = 1'b0;
      mem_waddr     = cur_ix[AW-1:0];
      mem_wdata     = '0;
      msb_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in        = req_tuser;
               off_in        = req_tdata;
               word_ix_in    = XW'(req_tdata >> BIT_W);
               res_off_in    = req_tdata;
               res_app_in    = 1'b0;
               res_isdel_in  = 1'b0;
               res_status_in = ST_OK;
               unique case (req_tuser)
                  CMD_ALLOC: begin
                     if (del_total_ff != '0) begin
                        vidx_in  = '0;
                        state_in = S_FLAG_SCAN;
                     end else if (node_count_ff >= CW'(MAX_NODES)) begin
                        res_off_in    = '0;
                        res_status_in = ST_FULL;
                        state_in      = S_RESULT;
                     end else begin
                        // Append; zero a bitmap word the first time the count enters it
                        res_off_in    = OFF_W'(node_count_ff);
                        res_app_in    = 1'b1;
                        node_count_in = node_count_ff + 1'b1;
                        if (node_count_ff[BIT_W-1:0] == '0) begin
                           mem_we    = 1'b1;
                           mem_waddr = AW'(node_count_ff >> BIT_W);
                        end
                        state_in = S_RESULT;
                     end
                  end
                  CMD_DELETE: begin
                     if (EW'(req_tdata) >= EW'(node_count_ff)) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_RD_WAIT;
                     end
                  end
                  CMD_TEST: begin
                     state_in = S_RD_WAIT;
                  end
                  CMD_UNUSED: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end

         S_RD_WAIT: begin
            state_in = S_CHK;
         end

         S_CHK: begin
            if (cmd_ff == CMD_DELETE) begin
               if (cur_word[off_ff[BIT_W-1:0]]) begin
                  res_status_in = ST_ALREADY;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = cur_word
                     | ({{(WORD_BITS-1){1'b0}}, 1'b1} << off_ff[BIT_W-1:0]);
                  flags_in[del_vec] = 1'b1;
                  del_total_in      = del_total_ff + 1'b1;
               end
            end else begin
               res_isdel_in = cur_word[off_ff[BIT_W-1:0]];
            end
            state_in = S_RESULT;
         end

         S_FLAG_SCAN: begin
            // Step to the lowest flagged vector
            if (flags_ff[vidx_ff]) begin
               widx_in  = WIW'(WPV - 1);
               state_in = S_SCAN_WAIT;
            end else begin
               vidx_in = vidx_ff + 1'b1;
            end
         end

         S_SCAN_WAIT: begin
            state_in = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            // Walk down the vector's words until one holds a deleted offset
            if (cur_word != '0) begin
               msb_start    = 1'b1;
               hold_word_in = cur_word;
               state_in     = S_MSB_WAIT;
            end else begin
               widx_in  = widx_ff - 1'b1;
               state_in = S_SCAN_WAIT;
            end
         end

         S_MSB_WAIT: begin
            if (msb_res.done) begin
               mem_we       = 1'b1;
               mem_wdata    = new_word;
               res_off_in   = OFF_W'({scan_ix, msb_res.bit_idx});
               del_total_in = del_total_ff - 1'b1;
               if (new_word != '0) begin
                  state_in = S_RESULT;
               end else if (widx_ff == '0) begin
                  flags_in[vidx_ff] = 1'b0;
                  state_in          = S_RESULT;
               end else begin
                  widx_in  = widx_ff - 1'b1;
                  state_in = S_EMPTY_WAIT;
               end
            end
         end

         S_EMPTY_WAIT: begin
            state_in = S_EMPTY_CHK;
         end

         S_EMPTY_CHK: begin
            // Drop the vector flag once no lower word holds a deletion
            if (cur_word != '0) begin
               state_in = S_RESULT;
            end else if (widx_ff == '0) begin
               flags_in[vidx_ff] = 1'b0;
               state_in          = S_RESULT;
            end else begin
               widx_in  = widx_ff - 1'b1;
               state_in = S_EMPTY_WAIT;
            end
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_off_in    = res_off_ff;
               rsp_app_in    = res_app_ff;
               rsp_isdel_in  = res_isdel_ff;
               rsp_status_in = res_status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= '0;
         del_total_ff  <= '0;
         flags_ff      <= '0;
         vidx_ff       <= '0;
         widx_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         del_total_ff  <= del_total_in;
         flags_ff      <= flags_in;
         vidx_ff       <= vidx_in;
         widx_ff       <= widx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      off_ff        <= off_in;
      word_ix_ff    <= word_ix_in;
      hold_word_ff  <= hold_word_in;
      res_off_ff    <= res_off_in;
      res_app_ff    <= res_app_in;
      res_isdel_ff  <= res_isdel_in;
      res_status_ff <= res_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_app_ff    <= rsp_app_in;
      rsp_isdel_ff  <= rsp_isdel_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_off_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_isdel_ff, rsp_app_ff};

   `ASSERT_CLK(a_flags_need_deletions, clock, reset, (state_ff == S_IDLE && del_total_ff == '0) |-> (flags_ff == '0), "vector flag set with no deleted offsets")
   `ASSERT_CLK(a_deleted_within_count, clock, reset, del_total_ff <= node_count_ff, "more deleted offsets than allocated")
   `ASSERT_CLK(a_count_capped, clock, reset, node_count_ff <= CW'(MAX_NODES), "node count beyond table size")
   `ASSERT_CLK(a_scan_on_flag, clock, reset, (state_ff == S_SCAN_CHK) |-> flags_ff[vidx_ff], "word scan in an unflagged vector")
   `ASSERT_NEXT(a_msb_latency, clock, reset, msb_start, ##1 msb_res.done, "highest-bit unit missed its latency")

endmodule

// ===== hdl/nida_msb.sv =====
// Registered highest-set-bit finder for one 64-bit bitmap word.
`timescale 1ns / 1ps

module nida_msb
   import nida_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] word,
   output msb_res_type          res
);

   localparam int BYTES = WORD_BITS / 8;

   logic                     stg_valid_ff;
   logic [$clog2(BYTES)-1:0] byte_ix_ff, byte_ix_in;
   logic [7:0]               byte_ff, byte_in;
   logic [2:0]               bit_ix;
   logic                     done_ff;
   logic [BIT_W-1:0]         idx_ff;

   // Pick the highest nonzero byte
   always_comb begin
      byte_ix_in = '0;
      for (int i = 0; i < BYTES; i++) begin
         if (|word[8*i +: 8]) begin
            byte_ix_in = i[$clog2(BYTES)-1:0];
         end
      end
      byte_in = word[8*byte_ix_in +: 8];
   end

   // Pick the highest set bit inside that byte
   always_comb begin
      bit_ix = '0;
      for (int i = 0; i < 8; i++) begin
         if (byte_ff[i]) begin
            bit_ix = i[2:0];
         end
      end
   end

   // Advance the two stages
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         stg_valid_ff <= start;
         done_ff      <= stg_valid_ff;
      end
      byte_ix_ff <= byte_ix_in;
      byte_ff    <= byte_in;
      idx_ff     <= {byte_ix_ff, bit_ix};
   end

   assign res.done    = done_ff;
   assign res.bit_idx = idx_ff;

endmodule

// ===== tb/sv/node_id_allocator_with_reuse_core_test.sv =====
// Self-checking testbench for the node offset allocator with reuse of deleted offsets.
`timescale 1ns / 1ps

module node_id_allocator_with_reuse_core_test;
   import nida_pkg::*;

   localparam int MAX_NODES   = DEF_MAX_NODES;
   localparam int VECTOR_SIZE = DEF_VECTOR_SIZE;
   localparam int NUM_VECTORS = (MAX_NODES + VECTOR_SIZE - 1) / VECTOR_SIZE;
   localparam int DRAIN_CYCLES = 200;

   // Fields of one response transaction
   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic             appended;
      logic             is_deleted;
      status_type       status;
   } alloc_result_type;

   // Mirror of the allocator state plus the responses still owed by the block
   class offset_ledger;
      logic [16:0]      node_count;
      int               deleted_total;
      bit               deleted_map [0:MAX_NODES-1];
      int               vector_fill [0:NUM_VECTORS-1];
      alloc_result_type expected_results [$];
      int               mismatches;

      function new();
         node_count    = '0;
         deleted_total = 0;
         mismatches    = 0;
         foreach (deleted_map[i]) deleted_map[i] = 1'b0;
         foreach (vector_fill[i]) vector_fill[i] = 0;
      endfunction

      // Apply one accepted command and queue the response it must produce
      function void note_command(cmd_type cmd, logic [OFF_W-1:0] off);
         alloc_result_type want;
         int               v;
         int               pos;
         bit               found;
         want            = '0;
         want.offset     = off;
         want.status     = ST_OK;
         case (cmd)
            CMD_ALLOC: begin
               if (deleted_total != 0) begin
                  // take the highest deleted offset of the lowest vector holding any
                  found = 1'b0;
                  for (v = 0; v < NUM_VECTORS && !found; v++) begin
                     if (vector_fill[v] != 0) begin
                        for (pos = (v + 1) * VECTOR_SIZE - 1;
                             pos >= v * VECTOR_SIZE && !found; pos--) begin
                           if (deleted_map[pos]) begin
                              deleted_map[pos] = 1'b0;
                              vector_fill[v]--;
                              deleted_total--;
                              want.offset = pos[OFF_W-1:0];
                              found = 1'b1;
                           end
                        end
                     end
                  end
               end else if (node_count >= MAX_NODES) begin
                  want.offset = '0;
                  want.status = ST_FULL;
               end else begin
                  want.offset   = node_count[OFF_W-1:0];
                  want.appended = 1'b1;
                  node_count++;
               end
            end
            CMD_DELETE: begin
               if ({1'b0, off} >= node_count) begin
                  want.status = ST_RANGE;
               end else if (deleted_map[off]) begin
                  want.status = ST_ALREADY;
               end else begin
                  deleted_map[off] = 1'b1;
                  vector_fill[int'(off) / VECTOR_SIZE]++;
                  deleted_total++;
               end
            end
            CMD_TEST: begin
               want.is_deleted = deleted_map[off];
            end
            default: begin
               // unused command: echo only
            end
         endcase
         expected_results = {expected_results, want};
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      task report_mismatch(string what);
         if (mismatches < 40) $display("%0t ns mismatch: %s", $time, what);
         mismatches++;
      endtask

      // Compare one response transaction with the oldest expectation
      task check_result(logic [OFF_W-1:0] data, logic [3:0] user);
         alloc_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response offset %0d tuser %b", data, user));
            return;
         end
         want = expected_results.pop_front();
         if (data !== want.offset)
            report_mismatch($sformatf("offset_out %0d, want %0d", data, want.offset));
         if (user[0] !== want.appended)
            report_mismatch($sformatf("appended %b, want %b (offset %0d)",
                                      user[0], want.appended, want.offset));
         if (user[1] !== want.is_deleted)
            report_mismatch($sformatf("is_deleted %b, want %b (offset %0d)",
                                      user[1], want.is_deleted, want.offset));
         if (user[3:2] !== want.status)
            report_mismatch($sformatf("status %0d, want %0d (offset %0d)",
                                      user[3:2], want.status, want.offset));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [OFF_W-1:0] req_tdata;   // [15:0] node_offset
   logic [CMD_W-1:0] req_tuser;   // [1:0] command
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [OFF_W-1:0] rsp_tdata;   // [15:0] offset_out
   logic [3:0]       rsp_tuser;   // [0] appended, [1] is_deleted, [3:2] status

   offset_ledger sb;
   bit           quiet;          // no idling on either side while set
   bit           hold_request;   // ask the receiver for one long hold-off
   int unsigned  hot_base;

   node_id_allocator_with_reuse_core #(
      .MAX_NODES   (MAX_NODES),
      .VECTOR_SIZE (VECTOR_SIZE)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one command and hold it until the block takes the transaction
   task send_request(cmd_type cmd, logic [OFF_W-1:0] off);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 22) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = off;
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, off);
   endtask

   // Random command, offsets biased toward a small window and the count edge
   task send_random_command();
      int unsigned      kind;
      int unsigned      pick;
      logic [OFF_W-1:0] off;
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (pick < 10)
         off = OFF_W'($urandom_range(0, 16'hFFFF));
      else if (pick < 16)
         off = OFF_W'(sb.node_count - $urandom_range(0, 1));
      else if (pick < 60)
         off = OFF_W'(hot_base + $urandom_range(0, 63));
      else
         off = OFF_W'($urandom_range(0, sb.node_count - 1));
      if (kind < 36)
         send_request(CMD_ALLOC, off);
      else if (kind < 70)
         send_request(CMD_DELETE, off);
      else if (kind < 95)
         send_request(CMD_TEST, off);
      else
         send_request(CMD_UNUSED, off);
   endtask

   // Receiver: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 400;
            rsp_tready   = 1'b0;
         end else begin
            rsp_tready = quiet || ($urandom_range(0, 99) >= 22);
         end
      end
   end

   // Check every response transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Bound the run
   initial begin
      #50_000_000;
      $display("node_id_allocator_with_reuse_core_test: FAIL");
      $finish;
   end

   initial begin
      sb           = new();
      quiet        = 1'b0;
      hold_request = 1'b0;
      hot_base     = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = CMD_ALLOC;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table: deletes are out of range, nothing tests as deleted
      send_request(CMD_TEST, 16'h0000);
      send_request(CMD_DELETE, 16'h0000);
      send_request(CMD_DELETE, 16'hFFFF);
      send_request(CMD_UNUSED, 16'hFFFF);
      send_request(CMD_TEST, 16'hFFFF);
      // append, then delete twice, delete at the count, reuse highest first
      send_request(CMD_ALLOC, 16'hFFFF);
      send_request(CMD_ALLOC, 16'h0000);
      send_request(CMD_ALLOC, 16'hA5A5);
      send_request(CMD_DELETE, 16'd1);
      send_request(CMD_DELETE, 16'd1);
      send_request(CMD_TEST, 16'd1);
      send_request(CMD_TEST, 16'd2);
      send_request(CMD_DELETE, 16'd3);
      send_request(CMD_DELETE, 16'd0);
      send_request(CMD_ALLOC, 16'h5A5A);
      send_request(CMD_ALLOC, 16'h0001);
      send_request(CMD_ALLOC, 16'h8000);
      send_request(CMD_UNUSED, 16'h5A5A);
      send_request(CMD_TEST, 16'd0);

      // grow over several bitmap words so reuse has to scan among them
      while (sb.node_count < 17'd256)
         send_request(CMD_ALLOC, OFF_W'($urandom_range(0, 16'hFFFF)));

      // random mix with one long receiver hold-off and a stretch without idling
      for (int i = 0; i < 1000; i++) begin
         if (i == 200) hold_request = 1'b1;
         quiet = (i >= 600 && i < 900);
         if (i % 64 == 0) hot_base = $urandom_range(0, sb.node_count - 64);
         send_random_command();
      end
      quiet = 1'b0;

      // deletions in several words, then reuse highest first
      send_request(CMD_DELETE, 16'd63);
      send_request(CMD_DELETE, 16'd64);
      send_request(CMD_DELETE, 16'd2);
      send_request(CMD_DELETE, 16'd200);
      send_request(CMD_TEST, 16'd64);
      repeat (5) send_request(CMD_ALLOC, OFF_W'($urandom_range(0, 16'hFFFF)));
      send_request(CMD_TEST, 16'd63);

      @(negedge clock);
      req_tvalid = 1'b0;

      // drain, then allow the longest reuse latency for stray responses
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("node_id_allocator_with_reuse_core_test: PASS");
      end else begin
         $display("node_id_allocator_with_reuse_core_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nida_pkg.sv
hdl/nida_msb.sv
hdl/node_id_allocator_with_reuse_core.sv
tb/sv/node_id_allocator_with_reuse_core_test.sv
